/* sv/gwp_pkg.sv */
// Shared types, constants and helper functions of the G-code word parser.
`timescale 1ns / 1ps
`default_nettype none

package gwp_pkg;

   // Word and coordinate widths
   localparam int CODE_WIDTH      = 21;
   localparam int CODE_GROW       = CODE_WIDTH + 4;
   localparam int COORD_WIDTH     = 32;
   localparam int COORD_GROW      = COORD_WIDTH + 4;
   localparam int FRACTION_DIGITS = 3;
   localparam int FRAC_CNT_W      = $clog2(FRACTION_DIGITS + 1);
   localparam int NUM_CODES       = 6;
   localparam int NUM_COORDS      = 5;

   // Character codes
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_DOT   = 8'h2e;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CASE_BIT   = 8'h20;
   localparam logic [7:0] LOWER_G    = 8'h67;
   localparam logic [7:0] LOWER_M    = 8'h6d;
   localparam logic [7:0] LOWER_P    = 8'h70;
   localparam logic [7:0] LOWER_S    = 8'h73;
   localparam logic [7:0] LOWER_F    = 8'h66;
   localparam logic [7:0] LOWER_T    = 8'h74;
   localparam logic [7:0] LOWER_X    = 8'h78;
   localparam logic [7:0] LOWER_Y    = 8'h79;
   localparam logic [7:0] LOWER_Z    = 8'h7a;
   localparam logic [7:0] LOWER_I    = 8'h69;
   localparam logic [7:0] LOWER_J    = 8'h6a;

   typedef logic signed [CODE_WIDTH-1:0]  code_type;
   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   // Decoded view of one character
   typedef struct packed {
      logic                  is_end;
      logic                  is_space;
      logic                  is_digit;
      logic [3:0]            digit;
      logic                  is_minus;
      logic                  is_dot;
      logic [NUM_CODES-1:0]  code_hit;
      logic [NUM_COORDS-1:0] coord_hit;
   } gwp_char_type;

   // 10^e, elaboration only
   function automatic logic [COORD_GROW-1:0] pow_ten(input int e);
      logic [COORD_GROW-1:0] r;
      r = COORD_GROW'(1);
      for (int k = 0; k < e; k++) begin
         r = COORD_GROW'(r * COORD_GROW'(10));
      end
      return r;
   endfunction

   // Weight of the next fraction digit when cnt digits are already taken
   function automatic logic [COORD_GROW-1:0] frac_weight(input logic [FRAC_CNT_W-1:0] cnt);
      logic [COORD_GROW-1:0] r;
      r = COORD_GROW'(1);
      for (int k = 0; k < FRACTION_DIGITS; k++) begin
         if (k + int'(cnt) < FRACTION_DIGITS - 1) begin
            r = COORD_GROW'(r * COORD_GROW'(10));
         end
      end
      return r;
   endfunction

   localparam logic [COORD_GROW-1:0] COORD_SCALE = pow_ten(FRACTION_DIGITS);
   localparam logic [COORD_GROW-1:0] COORD_CAP   = COORD_GROW'(64'd1 << (COORD_WIDTH - 1));
   localparam logic [COORD_WIDTH-1:0] COORD_POS_MAX =
      COORD_WIDTH'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
   localparam logic [CODE_GROW-1:0] CODE_MAX =
      CODE_GROW'((64'd1 << (CODE_WIDTH - 1)) - 64'd1);
   localparam code_type CODE_ABSENT_GM    = code_type'(-2);
   localparam code_type CODE_ABSENT_OTHER = code_type'(-1);
   localparam code_type CODE_NO_DIGITS    = code_type'(-1);

endpackage

`default_nettype wire

/* sv/gwp_ifs.sv */
// Valid/ready channel interfaces for character items and parsed line items.
`timescale 1ns / 1ps
`default_nettype none

interface gwp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

interface gwp_rsp_if;
   import gwp_pkg::*;

   logic                  valid;
   logic                  ready;
   code_type              g_code;
   code_type              m_code;
   code_type              p_value;
   code_type              s_value;
   code_type              f_value;
   code_type              t_value;
   coord_type             x_value;
   coord_type             y_value;
   coord_type             z_value;
   coord_type             i_value;
   coord_type             j_value;
   logic [NUM_COORDS-1:0] present_mask;

   modport source (output valid, input ready,
                   output g_code, m_code, p_value, s_value, f_value, t_value,
                   output x_value, y_value, z_value, i_value, j_value, present_mask);
   modport sink   (input valid, output ready,
                   input g_code, m_code, p_value, s_value, f_value, t_value,
                   input x_value, y_value, z_value, i_value, j_value, present_mask);
endinterface

`default_nettype wire

/* sv/gwp_char_decode.sv */
// Character classifier: end, space, digit, sign, point and word letters.
`timescale 1ns / 1ps
`default_nettype none

module gwp_char_decode (
   input  wire logic [7:0]           char_code,
   output gwp_pkg::gwp_char_type     char_info
);
   import gwp_pkg::*;

   logic [7:0] lower;

   always_comb begin
      lower = char_code | CASE_BIT;
      char_info.is_end   = (char_code == CHAR_NUL);
      char_info.is_space = (char_code == CHAR_SPACE);
      char_info.is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
      char_info.digit    = 4'(char_code - CHAR_ZERO);
      char_info.is_minus = (char_code == CHAR_MINUS);
      char_info.is_dot   = (char_code == CHAR_DOT);
      // letter codes with the case bit forced are always true letters
      char_info.code_hit[0]  = (lower == LOWER_G);
      char_info.code_hit[1]  = (lower == LOWER_M);
      char_info.code_hit[2]  = (lower == LOWER_P);
      char_info.code_hit[3]  = (lower == LOWER_S);
      char_info.code_hit[4]  = (lower == LOWER_F);
      char_info.code_hit[5]  = (lower == LOWER_T);
      char_info.coord_hit[0] = (lower == LOWER_X);
      char_info.coord_hit[1] = (lower == LOWER_Y);
      char_info.coord_hit[2] = (lower == LOWER_Z);
      char_info.coord_hit[3] = (lower == LOWER_I);
      char_info.coord_hit[4] = (lower == LOWER_J);
   end

endmodule

`default_nettype wire

/* sv/gwp_code_word.sv */
// Integer word accumulator (G, M, P, S, F or T) with saturation.
`timescale 1ns / 1ps
`default_nettype none

module gwp_code_word (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire gwp_pkg::gwp_char_type char_info,
   input  wire logic                 hit,
   input  wire gwp_pkg::code_type    absent_value,
   output gwp_pkg::code_type         code_value
);
   import gwp_pkg::*;

   code_type             acc_ff, acc_in;
   logic                 active_ff, active_in;
   logic                 seen_ff, seen_in;
   logic [CODE_GROW-1:0] acc_wide;
   logic [CODE_GROW-1:0] digit_wide;
   logic [CODE_GROW-1:0] next_wide;

   // Next value: acc*10 + digit (the digit alone for the first digit), clamped to CODE_MAX
   always_comb begin
      acc_wide   = CODE_GROW'(acc_ff[CODE_WIDTH-1:0]);
      digit_wide = CODE_GROW'(char_info.digit);
      if (seen_ff) begin
         next_wide = (acc_wide << 3) + (acc_wide << 1) + digit_wide;
      end else begin
         next_wide = digit_wide;
      end
      if (next_wide > CODE_MAX) begin
         next_wide = CODE_MAX;
      end
   end

   // Word state update for one item
   always_comb begin
      acc_in    = acc_ff;
      active_in = active_ff;
      seen_in   = seen_ff;
      if (step) begin
         if (char_info.is_end) begin
            acc_in    = absent_value;
            active_in = 1'b0;
            seen_in   = 1'b0;
         end else if (char_info.is_space) begin
            active_in = 1'b0;
         end else if (hit) begin
            acc_in    = CODE_NO_DIGITS;
            active_in = 1'b1;
            seen_in   = 1'b0;
         end else if (active_ff && char_info.is_digit) begin
            acc_in  = code_type'(next_wide[CODE_WIDTH-1:0]);
            seen_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= absent_value;
         active_ff <= 1'b0;
         seen_ff   <= 1'b0;
      end else begin
         acc_ff    <= acc_in;
         active_ff <= active_in;
         seen_ff   <= seen_in;
      end
   end

   assign code_value = acc_ff;

endmodule

`default_nettype wire

/* sv/gwp_coord_word.sv */
// Signed decimal word accumulator (X, Y, Z, I or J) in fixed point.
`timescale 1ns / 1ps
`default_nettype none

module gwp_coord_word (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire gwp_pkg::gwp_char_type char_info,
   input  wire logic                 hit,
   output gwp_pkg::coord_type        coord_value,
   output logic                      present
);
   import gwp_pkg::*;

   logic [COORD_WIDTH-1:0] acc_ff, acc_in;
   logic                   present_ff, present_in;
   logic                   active_ff, active_in;
   logic                   neg_ff, neg_in;
   logic                   frac_ff, frac_in;
   logic                   seen_ff, seen_in;
   logic [FRAC_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [COORD_GROW-1:0]  acc_wide;
   logic [COORD_GROW-1:0]  digit_wide;
   logic [COORD_GROW-1:0]  next_wide;
   logic                   frac_room;

   // Magnitude after one digit, clamped to 2^31
   always_comb begin
      acc_wide   = COORD_GROW'(acc_ff);
      digit_wide = COORD_GROW'(char_info.digit);
      frac_room  = (int'(cnt_ff) < FRACTION_DIGITS);
      if (!frac_ff) begin
         next_wide = COORD_GROW'((acc_wide << 3) + (acc_wide << 1)
                                 + COORD_GROW'(digit_wide * COORD_SCALE));
      end else if (frac_room) begin
         next_wide = COORD_GROW'(acc_wide + COORD_GROW'(digit_wide * frac_weight(cnt_ff)));
      end else begin
         next_wide = acc_wide;
      end
      if (next_wide > COORD_CAP) begin
         next_wide = COORD_CAP;
      end
   end

   // Word state update for one item
   always_comb begin
      acc_in     = acc_ff;
      present_in = present_ff;
      active_in  = active_ff;
      neg_in     = neg_ff;
      frac_in    = frac_ff;
      seen_in    = seen_ff;
      cnt_in     = cnt_ff;
      if (step) begin
         if (char_info.is_end) begin
            acc_in     = '0;
            present_in = 1'b0;
            active_in  = 1'b0;
            neg_in     = 1'b0;
            frac_in    = 1'b0;
            seen_in    = 1'b0;
            cnt_in     = '0;
         end else if (char_info.is_space) begin
            active_in = 1'b0;
         end else if (hit) begin
            acc_in     = '0;
            present_in = 1'b1;
            active_in  = 1'b1;
            neg_in     = 1'b0;
            frac_in    = 1'b0;
            seen_in    = 1'b0;
            cnt_in     = '0;
         end else if (active_ff) begin
            if (char_info.is_digit) begin
               seen_in = 1'b1;
               acc_in  = next_wide[COORD_WIDTH-1:0];
               if (frac_ff && frac_room) begin
                  cnt_in = cnt_ff + FRAC_CNT_W'(1);
               end
            end else if (char_info.is_minus && !frac_ff) begin
               neg_in = 1'b1;
            end else if (char_info.is_dot) begin
               frac_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff     <= '0;
         present_ff <= 1'b0;
         active_ff  <= 1'b0;
         neg_ff     <= 1'b0;
         frac_ff    <= 1'b0;
         seen_ff    <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         acc_ff     <= acc_in;
         present_ff <= present_in;
         active_ff  <= active_in;
         neg_ff     <= neg_in;
         frac_ff    <= frac_in;
         seen_ff    <= seen_in;
         cnt_ff     <= cnt_in;
      end
   end

   // Signed result: absent 0, no digits -1.0, else signed magnitude (positive clamped to COORD_POS_MAX)
   always_comb begin
      if (!present_ff) begin
         coord_value = '0;
      end else if (!seen_ff) begin
         coord_value = coord_type'(COORD_WIDTH'(0) - COORD_SCALE[COORD_WIDTH-1:0]);
      end else if (neg_ff) begin
         coord_value = coord_type'(COORD_WIDTH'(0) - acc_ff);
      end else if (acc_ff > COORD_POS_MAX) begin
         coord_value = coord_type'(COORD_POS_MAX);
      end else begin
         coord_value = coord_type'(acc_ff);
      end
   end

   assign present = present_ff;

endmodule

`default_nettype wire

/* sv/gcode_word_parser_core.sv */
// Top level of the G-code word parser: input register, word units, result register.
// A line's zero byte waits in the input register; its words go to the result register once that slot is free.
// Throughput: one character per cycle; a zero byte waits only while the result
// register still holds an untaken line.
// Reset: synchronous, active high; clears the input and result valid flags and
// returns every word to its absent default.
`timescale 1ns / 1ps
`default_nettype none

module gcode_word_parser_core (
   input  wire logic  clock,
   input  wire logic  reset,
   gwp_req_if.sink    req_ch,
   gwp_rsp_if.source  rsp_ch
);
   import gwp_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_char_ff, in_char_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   gwp_char_type          char_info;
   logic                  out_free;
   logic                  step;
   logic                  emit;
   code_type              code_value [NUM_CODES];
   coord_type             coord_value [NUM_COORDS];
   logic [NUM_COORDS-1:0] present;

   code_type              g_ff, m_ff, p_ff, s_ff, f_ff, t_ff;
   coord_type             x_ff, y_ff, z_ff, i_ff, j_ff;
   logic [NUM_COORDS-1:0] mask_ff;

   gwp_char_decode u_decode (
      .char_code (in_char_ff),
      .char_info (char_info)
   );

   // Handshake: a held item advances unless it ends a line and the result slot is busy
   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ch.ready;
      step         = in_valid_ff && (!char_info.is_end || out_free);
      emit         = step && char_info.is_end;
      req_ch.ready = !in_valid_ff || step;
      in_valid_in  = in_valid_ff;
      in_char_in   = in_char_ff;
      if (req_ch.valid && req_ch.ready) begin
         in_valid_in = 1'b1;
         in_char_in  = req_ch.char_code;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Word units
   for (genvar k = 0; k < NUM_CODES; k++) begin : g_code_words
      gwp_code_word u_code (
         .clock        (clock),
         .reset        (reset),
         .step         (step),
         .char_info    (char_info),
         .hit          (char_info.code_hit[k]),
         .absent_value ((k < 2) ? CODE_ABSENT_GM : CODE_ABSENT_OTHER),
         .code_value   (code_value[k])
      );
   end

   for (genvar k = 0; k < NUM_COORDS; k++) begin : g_coord_words
      gwp_coord_word u_coord (
         .clock       (clock),
         .reset       (reset),
         .step        (step),
         .char_info   (char_info),
         .hit         (char_info.coord_hit[k]),
         .coord_value (coord_value[k]),
         .present     (present[k])
      );
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_char_ff <= in_char_in;
      if (emit) begin
         g_ff    <= code_value[0];
         m_ff    <= code_value[1];
         p_ff    <= code_value[2];
         s_ff    <= code_value[3];
         f_ff    <= code_value[4];
         t_ff    <= code_value[5];
         x_ff    <= coord_value[0];
         y_ff    <= coord_value[1];
         z_ff    <= coord_value[2];
         i_ff    <= coord_value[3];
         j_ff    <= coord_value[4];
         mask_ff <= present;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.g_code       = g_ff;
   assign rsp_ch.m_code       = m_ff;
   assign rsp_ch.p_value      = p_ff;
   assign rsp_ch.s_value      = s_ff;
   assign rsp_ch.f_value      = f_ff;
   assign rsp_ch.t_value      = t_ff;
   assign rsp_ch.x_value      = x_ff;
   assign rsp_ch.y_value      = y_ff;
   assign rsp_ch.z_value      = z_ff;
   assign rsp_ch.i_value      = i_ff;
   assign rsp_ch.j_value      = j_ff;
   assign rsp_ch.present_mask = mask_ff;

endmodule

`default_nettype wire
